/* hdl/grid_line_run_merger_core_macros.svh */
// Assertion macros for the grid line run merger.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef GRID_LINE_RUN_MERGER_CORE_MACROS_SVH
`define GRID_LINE_RUN_MERGER_CORE_MACROS_SVH

`ifndef SYNTH
`define GLRM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define GLRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define GLRM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GLRM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/glrm_pkg.sv */
// Shared types and constants for the grid line run merger.
// No dependencies.
`timescale 1ns / 1ps

package glrm_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int MAX_RUN_DEF    = 65535;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 8;
    localparam int OP_BITS        = 2;
    localparam int CMD_BITS       = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_HLINE = 2'd0,
        OP_VLINE = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LINE   = 2'd0,
        CMD_GRID_H = 2'd1,
        CMD_GRID_V = 2'd2
    } cmd_t;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MERGE_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_STEP_X = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_STEP_Y = 2'd2;

    typedef struct packed {
        logic       merge_enable;
        logic [7:0] pixel_step_x;
        logic [7:0] pixel_step_y;
    } cfg_t;

endpackage

/* hdl/glrm_cfg_regs.sv */
// Configuration registers: merge enable and the two pixel join steps.
// Depends on glrm_pkg.
`timescale 1ns / 1ps

module glrm_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [glrm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [glrm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output glrm_pkg::cfg_t                       cfg
);
    import glrm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MERGE_ENABLE: cfg_next.merge_enable = cfg_data[0];
                REG_PIXEL_STEP_X: cfg_next.pixel_step_x = cfg_data;
                REG_PIXEL_STEP_Y: cfg_next.pixel_step_y = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.merge_enable <= 1'b1;
            cfg_reg.pixel_step_x <= 8'd1;
            cfg_reg.pixel_step_y <= 8'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/glrm_in_reg.sv */
// Input register: captures one line item and holds it until the engine takes it.
// Depends on glrm_pkg.
`timescale 1ns / 1ps

module glrm_in_reg
#(
    parameter int COORD_BITS = glrm_pkg::COORD_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [glrm_pkg::OP_BITS-1:0]        operation,
    input  logic signed [COORD_BITS-1:0]        span_start,
    input  logic signed [COORD_BITS-1:0]        span_end,
    input  logic signed [COORD_BITS-1:0]        line_position,
    input  logic                                go,
    output logic                                item_valid,
    output logic [glrm_pkg::OP_BITS-1:0]        item_op,
    output logic signed [COORD_BITS-1:0]        item_start,
    output logic signed [COORD_BITS-1:0]        item_end,
    output logic signed [COORD_BITS-1:0]        item_pos
);
    import glrm_pkg::*;

    logic                          item_valid_reg;
    logic                          item_valid_next;
    logic [OP_BITS-1:0]            item_op_reg;
    logic signed [COORD_BITS-1:0]  item_start_reg;
    logic signed [COORD_BITS-1:0]  item_end_reg;
    logic signed [COORD_BITS-1:0]  item_pos_reg;

    assign in_ready = !item_valid_reg || go;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_ready)
        begin
            item_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_op_reg    <= operation;
            item_start_reg <= span_start;
            item_end_reg   <= span_end;
            item_pos_reg   <= line_position;
        end
    end

    assign item_valid = item_valid_reg;
    assign item_op    = item_op_reg;
    assign item_start = item_start_reg;
    assign item_end   = item_end_reg;
    assign item_pos   = item_pos_reg;

endmodule

/* hdl/glrm_run_engine.sv */
// Run state and merge decision: updates the pending run and forms the result item.
// Depends on glrm_pkg and grid_line_run_merger_core_macros.svh.
`timescale 1ns / 1ps
`include "grid_line_run_merger_core_macros.svh"

module glrm_run_engine
#(
    parameter int COORD_BITS = glrm_pkg::COORD_BITS_DEF,
    parameter int MAX_RUN    = glrm_pkg::MAX_RUN_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  glrm_pkg::cfg_t                      cfg,
    input  logic                                go,
    input  logic [glrm_pkg::OP_BITS-1:0]        item_op,
    input  logic signed [COORD_BITS-1:0]        item_start,
    input  logic signed [COORD_BITS-1:0]        item_end,
    input  logic signed [COORD_BITS-1:0]        item_pos,
    output logic                                has_result,
    output logic [glrm_pkg::CMD_BITS-1:0]       res_command,
    output logic signed [COORD_BITS-1:0]        res_x_first,
    output logic signed [COORD_BITS-1:0]        res_y_first,
    output logic signed [COORD_BITS-1:0]        res_x_second,
    output logic signed [COORD_BITS-1:0]        res_y_second,
    output logic signed [COORD_BITS:0]          res_cell_width,
    output logic signed [COORD_BITS:0]          res_cell_height
);
    import glrm_pkg::*;

    localparam int W     = COORD_BITS;
    localparam int CNT_W = $clog2(MAX_RUN + 1);

    logic                  run_vertical_reg;
    logic                  run_vertical_next;
    logic [CNT_W-1:0]      run_count_reg;
    logic [CNT_W-1:0]      run_count_next;
    logic signed [W-1:0]   run_span_start_reg;
    logic signed [W-1:0]   run_span_end_reg;
    logic signed [W-1:0]   run_first_reg;
    logic signed [W-1:0]   run_last_reg;
    logic signed [W:0]     run_spacing_reg;

    logic                  is_line;
    logic                  vert;
    logic                  pending;
    logic                  single;
    logic                  full;
    logic                  span_eq;
    logic                  join_ok;
    logic                  pos_ok;
    logic [7:0]            step;
    logic signed [W:0]     step_ext;
    logic signed [W:0]     start_x;
    logic signed [W:0]     end_x;
    logic signed [W:0]     end_plus;
    logic signed [W+1:0]   next_pos;
    logic signed [W+1:0]   pos_x;
    logic signed [W:0]     new_spacing;

    logic                  act_start;
    logic                  act_extend;
    logic                  act_second;
    logic                  act_append;
    logic                  act_clear;
    logic                  emit_run;
    logic                  pass;

    logic signed [W:0]     span_len;
    logic                  swap;
    logic signed [W-1:0]   grid_a;
    logic signed [W-1:0]   grid_b;
    logic signed [W:0]     grid_d;

    assign is_line  = (item_op == OP_HLINE) || (item_op == OP_VLINE);
    assign vert     = (item_op == OP_VLINE);
    assign pending  = (run_count_reg != '0);
    assign single   = (run_count_reg == CNT_W'(1));
    assign full     = (run_count_reg >= CNT_W'(MAX_RUN));
    assign span_eq  = (item_start == run_span_start_reg) && (item_end == run_span_end_reg);
    assign step     = vert ? cfg.pixel_step_y : cfg.pixel_step_x;
    assign step_ext = $signed({{(W-7){1'b0}}, step});
    assign start_x  = {item_start[W-1], item_start};
    assign end_x    = {run_span_end_reg[W-1], run_span_end_reg};
    assign end_plus = end_x + step_ext;
    assign join_ok  = single && (item_pos == run_first_reg) &&
                      ((item_start == run_span_end_reg) || (start_x == end_plus));
    assign next_pos = {{2{run_last_reg[W-1]}}, run_last_reg} +
                      {run_spacing_reg[W], run_spacing_reg};
    assign pos_x    = {{2{item_pos[W-1]}}, item_pos};
    assign pos_ok   = (pos_x == next_pos);
    assign new_spacing = {item_pos[W-1], item_pos} - {run_first_reg[W-1], run_first_reg};

    always_comb
    begin
        act_start  = 1'b0;
        act_extend = 1'b0;
        act_second = 1'b0;
        act_append = 1'b0;
        act_clear  = 1'b0;
        emit_run   = 1'b0;
        pass       = 1'b0;
        priority if (item_op == OP_FLUSH)
        begin
            emit_run  = pending;
            act_clear = 1'b1;
        end
        else if (!is_line)
        begin
            emit_run = 1'b0;
        end
        else if (!cfg.merge_enable)
        begin
            pass = 1'b1;
        end
        else if (vert != run_vertical_reg)
        begin
            emit_run  = pending;
            act_start = 1'b1;
        end
        else if (!pending)
        begin
            act_start = 1'b1;
        end
        else if (!span_eq)
        begin
            if (join_ok)
            begin
                act_extend = 1'b1;
            end
            else
            begin
                emit_run  = 1'b1;
                act_start = 1'b1;
            end
        end
        else if (single)
        begin
            act_second = 1'b1;
        end
        else if (!pos_ok || full)
        begin
            emit_run  = 1'b1;
            act_start = 1'b1;
        end
        else
        begin
            act_append = 1'b1;
        end
    end

    assign has_result = emit_run || pass;

    // vertical grids with negative spacing swap left and right
    assign span_len = {run_span_end_reg[W-1], run_span_end_reg} -
                      {run_span_start_reg[W-1], run_span_start_reg};
    assign swap     = run_vertical_reg && run_spacing_reg[W];
    assign grid_a   = swap ? run_last_reg : run_first_reg;
    assign grid_b   = swap ? run_first_reg : run_last_reg;
    assign grid_d   = swap ? -run_spacing_reg : run_spacing_reg;

    always_comb
    begin
        res_command     = CMD_LINE;
        res_x_first     = '0;
        res_y_first     = '0;
        res_x_second    = '0;
        res_y_second    = '0;
        res_cell_width  = '0;
        res_cell_height = '0;
        priority if (pass)
        begin
            if (vert)
            begin
                res_x_first  = item_pos;
                res_y_first  = item_start;
                res_x_second = item_pos;
                res_y_second = item_end;
            end
            else
            begin
                res_x_first  = item_start;
                res_y_first  = item_pos;
                res_x_second = item_end;
                res_y_second = item_pos;
            end
        end
        else if (single)
        begin
            if (run_vertical_reg)
            begin
                res_x_first  = run_first_reg;
                res_y_first  = run_span_start_reg;
                res_x_second = run_first_reg;
                res_y_second = run_span_end_reg;
            end
            else
            begin
                res_x_first  = run_span_start_reg;
                res_y_first  = run_first_reg;
                res_x_second = run_span_end_reg;
                res_y_second = run_first_reg;
            end
        end
        else if (run_vertical_reg)
        begin
            res_command     = CMD_GRID_V;
            res_x_first     = grid_a;
            res_y_first     = run_span_start_reg;
            res_x_second    = grid_b;
            res_y_second    = run_span_end_reg;
            res_cell_width  = grid_d;
            res_cell_height = span_len;
        end
        else
        begin
            res_command     = CMD_GRID_H;
            res_x_first     = run_span_start_reg;
            res_y_first     = run_first_reg;
            res_x_second    = run_span_end_reg;
            res_y_second    = run_last_reg;
            res_cell_width  = span_len;
            res_cell_height = run_spacing_reg;
        end
    end

    always_comb
    begin
        run_vertical_next = run_vertical_reg;
        run_count_next    = run_count_reg;
        if (go)
        begin
            if (is_line && cfg.merge_enable)
            begin
                run_vertical_next = vert;
            end
            priority if (act_start)
            begin
                run_count_next = CNT_W'(1);
            end
            else if (act_second)
            begin
                run_count_next = CNT_W'(2);
            end
            else if (act_append)
            begin
                run_count_next = run_count_reg + CNT_W'(1);
            end
            else if (act_clear)
            begin
                run_count_next = '0;
            end
            else
            begin
                run_count_next = run_count_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_vertical_reg <= 1'b0;
            run_count_reg    <= '0;
        end
        else
        begin
            run_vertical_reg <= run_vertical_next;
            run_count_reg    <= run_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            if (act_start)
            begin
                run_span_start_reg <= item_start;
                run_span_end_reg   <= item_end;
                run_first_reg      <= item_pos;
                run_last_reg       <= item_pos;
                run_spacing_reg    <= '0;
            end
            if (act_extend)
            begin
                run_span_end_reg <= item_end;
            end
            if (act_second)
            begin
                run_spacing_reg <= new_spacing;
                run_last_reg    <= item_pos;
            end
            if (act_append)
            begin
                run_last_reg <= item_pos;
            end
        end
    end

    `GLRM_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, run_count_reg <= CNT_W'(MAX_RUN))
    `GLRM_ASSERT_IMPLY(a_flush_empty, clk, rst_n, (item_op == OP_FLUSH) && !pending, !has_result)
    `GLRM_ASSERT_NEXT(a_flush_clears, clk, rst_n, go && (item_op == OP_FLUSH), run_count_reg == '0)
    `GLRM_ASSERT_NEXT(a_line_opens, clk, rst_n, go && is_line && cfg.merge_enable, run_count_reg != '0)
    `GLRM_ASSERT_IMPLY(a_vgrid_pos, clk, rst_n, has_result && (res_command == CMD_GRID_V), !res_cell_width[W])

endmodule

/* hdl/glrm_out_reg.sv */
// Result register: holds one drawing command item until the consumer takes it.
// Depends on glrm_pkg.
`timescale 1ns / 1ps

module glrm_out_reg
#(
    parameter int COORD_BITS = glrm_pkg::COORD_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic [glrm_pkg::CMD_BITS-1:0]       res_command,
    input  logic signed [COORD_BITS-1:0]        res_x_first,
    input  logic signed [COORD_BITS-1:0]        res_y_first,
    input  logic signed [COORD_BITS-1:0]        res_x_second,
    input  logic signed [COORD_BITS-1:0]        res_y_second,
    input  logic signed [COORD_BITS:0]          res_cell_width,
    input  logic signed [COORD_BITS:0]          res_cell_height,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [glrm_pkg::CMD_BITS-1:0]       command,
    output logic signed [COORD_BITS-1:0]        x_first,
    output logic signed [COORD_BITS-1:0]        y_first,
    output logic signed [COORD_BITS-1:0]        x_second,
    output logic signed [COORD_BITS-1:0]        y_second,
    output logic signed [COORD_BITS:0]          cell_width,
    output logic signed [COORD_BITS:0]          cell_height
);
    import glrm_pkg::*;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [CMD_BITS-1:0]           command_reg;
    logic signed [COORD_BITS-1:0]  x_first_reg;
    logic signed [COORD_BITS-1:0]  y_first_reg;
    logic signed [COORD_BITS-1:0]  x_second_reg;
    logic signed [COORD_BITS-1:0]  y_second_reg;
    logic signed [COORD_BITS:0]    cell_width_reg;
    logic signed [COORD_BITS:0]    cell_height_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            command_reg     <= res_command;
            x_first_reg     <= res_x_first;
            y_first_reg     <= res_y_first;
            x_second_reg    <= res_x_second;
            y_second_reg    <= res_y_second;
            cell_width_reg  <= res_cell_width;
            cell_height_reg <= res_cell_height;
        end
    end

    assign out_valid   = out_valid_reg;
    assign command     = command_reg;
    assign x_first     = x_first_reg;
    assign y_first     = y_first_reg;
    assign x_second    = x_second_reg;
    assign y_second    = y_second_reg;
    assign cell_width  = cell_width_reg;
    assign cell_height = cell_height_reg;

endmodule

/* hdl/grid_line_run_merger_core.sv */
// Grid line run merger top level: input register, run engine, result register.
// Depends on glrm_pkg, glrm_cfg_regs, glrm_in_reg, glrm_run_engine, glrm_out_reg.
`timescale 1ns / 1ps

// Turns a stream of horizontal and vertical line items into drawing commands:
// single lines, or grid rectangles built from equally spaced lines of equal span.
// One item is taken per clock unless the input stalls. An item is held in the
// input register, and its result, if any, is loaded into the result register
// when it leaves. The input register holds one more item while a result
// waits; it stalls only when that item would produce a result and the result
// register is still full. Configuration writes take effect on the next edge
// and should be made while no item is in flight.

module grid_line_run_merger_core
#(
    parameter int MAX_RUN    = glrm_pkg::MAX_RUN_DEF,
    parameter int COORD_BITS = glrm_pkg::COORD_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [glrm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [glrm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [glrm_pkg::OP_BITS-1:0]        operation,
    input  logic signed [COORD_BITS-1:0]        span_start,
    input  logic signed [COORD_BITS-1:0]        span_end,
    input  logic signed [COORD_BITS-1:0]        line_position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [glrm_pkg::CMD_BITS-1:0]       command,
    output logic signed [COORD_BITS-1:0]        x_first,
    output logic signed [COORD_BITS-1:0]        y_first,
    output logic signed [COORD_BITS-1:0]        x_second,
    output logic signed [COORD_BITS-1:0]        y_second,
    output logic signed [COORD_BITS:0]          cell_width,
    output logic signed [COORD_BITS:0]          cell_height
);
    import glrm_pkg::*;

    cfg_t                          cfg;
    logic                          go;
    logic                          item_valid;
    logic [OP_BITS-1:0]            item_op;
    logic signed [COORD_BITS-1:0]  item_start;
    logic signed [COORD_BITS-1:0]  item_end;
    logic signed [COORD_BITS-1:0]  item_pos;
    logic                          has_result;
    logic [CMD_BITS-1:0]           res_command;
    logic signed [COORD_BITS-1:0]  res_x_first;
    logic signed [COORD_BITS-1:0]  res_y_first;
    logic signed [COORD_BITS-1:0]  res_x_second;
    logic signed [COORD_BITS-1:0]  res_y_second;
    logic signed [COORD_BITS:0]    res_cell_width;
    logic signed [COORD_BITS:0]    res_cell_height;

    assign go = item_valid && (!has_result || !out_valid || out_ready);

    glrm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    glrm_in_reg #(.COORD_BITS(COORD_BITS)) u_in
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .span_start    (span_start),
        .span_end      (span_end),
        .line_position (line_position),
        .go            (go),
        .item_valid    (item_valid),
        .item_op       (item_op),
        .item_start    (item_start),
        .item_end      (item_end),
        .item_pos      (item_pos)
    );

    glrm_run_engine #(.COORD_BITS(COORD_BITS), .MAX_RUN(MAX_RUN)) u_engine
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .go              (go),
        .item_op         (item_op),
        .item_start      (item_start),
        .item_end        (item_end),
        .item_pos        (item_pos),
        .has_result      (has_result),
        .res_command     (res_command),
        .res_x_first     (res_x_first),
        .res_y_first     (res_y_first),
        .res_x_second    (res_x_second),
        .res_y_second    (res_y_second),
        .res_cell_width  (res_cell_width),
        .res_cell_height (res_cell_height)
    );

    glrm_out_reg #(.COORD_BITS(COORD_BITS)) u_out
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (go && has_result),
        .res_command     (res_command),
        .res_x_first     (res_x_first),
        .res_y_first     (res_y_first),
        .res_x_second    (res_x_second),
        .res_y_second    (res_y_second),
        .res_cell_width  (res_cell_width),
        .res_cell_height (res_cell_height),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .command         (command),
        .x_first         (x_first),
        .y_first         (y_first),
        .x_second        (x_second),
        .y_second        (y_second),
        .cell_width      (cell_width),
        .cell_height     (cell_height)
    );

endmodule
